FILE: design/generational_handle_table_assert.svh
// assertion macros shared by the handle table modules
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GHT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ght_pkg.sv
// types and constants of the generational handle table
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

    localparam int unsigned GHT_ENTRIES = 1024;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned GEN_W       = 16;
    localparam int unsigned LOC_W       = 16;
    localparam int unsigned CNT_W       = IDX_W + 1;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned STAT_W      = 2;
    localparam int unsigned DATA_W      = 80;

    localparam logic [KIND_W-1:0] K_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] K_RECYCLE = 2'd1;
    localparam logic [KIND_W-1:0] K_LOOKUP  = 2'd2;
    localparam logic [KIND_W-1:0] K_REMAP   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_STALE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0] link;
        logic             link_valid;
        logic             occupied;
        logic [LOC_W-1:0] slot;
        logic [LOC_W-1:0] block;
        logic [LOC_W-1:0] group;
        logic [GEN_W-1:0] gen;
    } t_ght_entry;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ght_cmd;

endpackage

`default_nettype wire

FILE: design/ght_ctrl.sv
// handshake and sequencing controller of the handle table
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_table_assert.svh"

module ght_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire logic            i_m_tready,
    output ght_pkg::t_ght_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept, w_exec;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    // finish once the output register is empty or being drained
    assign w_exec     = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_cmd.load = w_accept;
    assign o_cmd.exec = w_exec;

    `GHT_ASSERT_NEXT(a_accept_to_exec, w_accept, r_state == S_EXEC, "accept did not start work")
    `GHT_ASSERT_NEXT(a_one_at_a_time, w_accept, !o_s_tready, "second word taken mid-operation")
    `GHT_ASSERT_NEXT(a_exec_fills_out, w_exec, o_m_tvalid, "result lost after execute")

endmodule

`default_nettype wire

FILE: design/ght_dpath.sv
// handle table datapath: entry memory, free list head, fill count, result register
`timescale 1ns / 1ps
`default_nettype none
`include "generational_handle_table_assert.svh"

module ght_dpath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ght_pkg::t_ght_cmd           i_cmd,
    input  wire logic [ght_pkg::DATA_W-1:0]  i_s_tdata,
    input  wire logic [ght_pkg::KIND_W-1:0]  i_s_tuser,
    output logic      [ght_pkg::DATA_W-1:0]  o_m_tdata,
    output logic      [ght_pkg::STAT_W-1:0]  o_m_tuser
);

    localparam int unsigned IW = ght_pkg::IDX_W;
    localparam int unsigned GW = ght_pkg::GEN_W;
    localparam int unsigned LW = ght_pkg::LOC_W;
    localparam int unsigned CW = ght_pkg::CNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(ght_pkg::GHT_ENTRIES);

    ght_pkg::t_ght_entry r_mem [ght_pkg::GHT_ENTRIES];
    ght_pkg::t_ght_entry r_rd;

    logic [ght_pkg::KIND_W-1:0] r_kind;
    logic [IW-1:0]              r_idx;
    logic [GW-1:0]              r_gen;
    logic [LW-1:0]              r_grp, r_blk, r_slt;

    logic [IW-1:0] r_fh, n_fh;
    logic          r_fh_valid, n_fh_valid;
    logic [CW-1:0] r_used, n_used;

    logic [IW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [IW-1:0]        w_wr_addr;
    ght_pkg::t_ght_entry  w_wr_data;
    logic                 w_ok;
    logic [GW-1:0]        w_rgen;

    logic [ght_pkg::STAT_W-1:0] n_st, r_st;
    logic [IW-1:0]              n_oidx, r_oidx;
    logic [GW-1:0]              n_ogen, r_ogen;
    logic [LW-1:0]              n_ogrp, r_ogrp, n_oblk, r_oblk, n_oslt, r_oslt;

    // read address chosen at accept time
    assign w_rd_addr = (i_s_tuser == ght_pkg::K_ALLOC) ? r_fh : i_s_tdata[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd   <= r_mem[w_rd_addr];
            r_kind <= i_s_tuser;
            r_idx  <= i_s_tdata[IW-1:0];
            r_gen  <= i_s_tdata[IW +: GW];
            r_grp  <= i_s_tdata[IW+GW +: LW];
            r_blk  <= i_s_tdata[IW+GW+LW +: LW];
            r_slt  <= i_s_tdata[IW+GW+2*LW +: LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    assign w_ok = ({1'b0, r_idx} < r_used) && r_rd.occupied && (r_rd.gen == r_gen);
    // recycle bump skips zero
    assign w_rgen = ((r_gen + GW'(1)) == '0) ? GW'(1) : (r_gen + GW'(1));

    always_comb begin
        n_fh       = r_fh;
        n_fh_valid = r_fh_valid;
        n_used     = r_used;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_idx;
        w_wr_data  = r_rd;
        n_st       = ght_pkg::ST_STALE;
        n_oidx     = r_idx;
        n_ogen     = '0;
        n_ogrp     = '0;
        n_oblk     = '0;
        n_oslt     = '0;
        case (r_kind)
            ght_pkg::K_ALLOC: begin
                w_wr_data.group      = r_grp;
                w_wr_data.block      = r_blk;
                w_wr_data.slot       = r_slt;
                w_wr_data.occupied   = 1'b1;
                w_wr_data.link_valid = 1'b0;
                w_wr_data.link       = '0;
                n_ogrp = r_grp;
                n_oblk = r_blk;
                n_oslt = r_slt;
                n_st   = ght_pkg::ST_OK;
                if (r_fh_valid) begin
                    w_wr_en       = 1'b1;
                    w_wr_addr     = r_fh;
                    w_wr_data.gen = r_rd.gen + GW'(1);
                    n_fh          = r_rd.link;
                    n_fh_valid    = r_rd.link_valid;
                    n_oidx        = r_fh;
                    n_ogen        = r_rd.gen + GW'(1);
                end else if (r_used != FULL_CNT) begin
                    w_wr_en       = 1'b1;
                    w_wr_addr     = r_used[IW-1:0];
                    w_wr_data.gen = GW'(1);
                    n_used        = r_used + CW'(1);
                    n_oidx        = r_used[IW-1:0];
                    n_ogen        = GW'(1);
                end else begin
                    n_st   = ght_pkg::ST_FULL;
                    n_oidx = '0;
                    n_ogrp = '0;
                    n_oblk = '0;
                    n_oslt = '0;
                end
            end
            ght_pkg::K_RECYCLE: begin
                if (w_ok) begin
                    w_wr_en              = 1'b1;
                    w_wr_data.gen        = w_rgen;
                    w_wr_data.group      = '0;
                    w_wr_data.block      = '0;
                    w_wr_data.slot       = '0;
                    w_wr_data.occupied   = 1'b0;
                    w_wr_data.link_valid = r_fh_valid;
                    w_wr_data.link       = r_fh;
                    n_fh                 = r_idx;
                    n_fh_valid           = 1'b1;
                    n_st                 = ght_pkg::ST_OK;
                    n_ogen               = w_rgen;
                end
            end
            ght_pkg::K_LOOKUP: begin
                if (w_ok) begin
                    n_st   = ght_pkg::ST_OK;
                    n_ogen = r_rd.gen;
                    n_ogrp = r_rd.group;
                    n_oblk = r_rd.block;
                    n_oslt = r_rd.slot;
                end
            end
            ght_pkg::K_REMAP: begin
                if (w_ok) begin
                    w_wr_en         = 1'b1;
                    w_wr_data.group = r_grp;
                    w_wr_data.block = r_blk;
                    w_wr_data.slot  = r_slt;
                    n_st            = ght_pkg::ST_OK;
                    n_ogen          = r_rd.gen;
                    n_ogrp          = r_grp;
                    n_oblk          = r_blk;
                    n_oslt          = r_slt;
                end
            end
            default: begin
                n_st = ght_pkg::ST_STALE;
            end
        endcase
        if (!i_cmd.exec) begin
            w_wr_en    = 1'b0;
            n_fh       = r_fh;
            n_fh_valid = r_fh_valid;
            n_used     = r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh       <= '0;
            r_fh_valid <= 1'b0;
            r_used     <= '0;
        end else begin
            r_fh       <= n_fh;
            r_fh_valid <= n_fh_valid;
            r_used     <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_st   <= n_st;
            r_oidx <= n_oidx;
            r_ogen <= n_ogen;
            r_ogrp <= n_ogrp;
            r_oblk <= n_oblk;
            r_oslt <= n_oslt;
        end
    end

    assign o_m_tuser = r_st;
    assign o_m_tdata = {(ght_pkg::DATA_W - IW - GW - 3*LW)'(0),
                        r_oslt, r_oblk, r_ogrp, r_ogen, r_oidx};

    `GHT_ASSERT_IMPL(a_used_bound, 1'b1, r_used <= FULL_CNT, "fill count beyond table size")
    `GHT_ASSERT_IMPL(a_head_in_use, r_fh_valid, {1'b0, r_fh} < r_used, "free head past fill count")
    `GHT_ASSERT_NEXT(a_alloc_grows, i_cmd.exec && (r_kind == ght_pkg::K_ALLOC) && !r_fh_valid
                     && (r_used != FULL_CNT), r_used == $past(r_used) + CW'(1),
                     "append did not advance fill count")

endmodule

`default_nettype wire

FILE: design/generational_handle_table.sv
// top level of the generational handle table
`timescale 1ns / 1ps
`default_nettype none

// Generational handle table: a slot map with a free list over 1024 entries.
// Each input word is one operation (allocate, recycle, lookup, remap) and
// gives exactly one result word. An operation first does the registered
// read of the entry memory, then the check, the entry write, the free-head
// and fill-count update and the load of the result register, once that
// register is empty or being drained. Operations run one at a time; a new
// word is taken while the previous result still waits in the output
// register. Entries are appended in order and freed entries are reused
// head-first, so no memory clearing is needed after reset.

module generational_handle_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // handle_index, handle_generation, location_group, location_block,
    // location_slot, zero pad
    input  wire logic [ght_pkg::DATA_W-1:0]  i_s_tdata,
    // kind
    input  wire logic [ght_pkg::KIND_W-1:0]  i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // out_index, out_generation, out_group, out_block, out_slot, zero pad
    output logic      [ght_pkg::DATA_W-1:0]  o_m_tdata,
    // status
    output logic      [ght_pkg::STAT_W-1:0]  o_m_tuser
);

    ght_pkg::t_ght_cmd w_cmd;

    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    ght_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for the generational handle table: directed table, fill, random
`timescale 1ns / 1ps

module tb_top;
    import ght_pkg::*;

    localparam int unsigned PAD_W = DATA_W - IDX_W - GEN_W - 3 * LOC_W;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic [LOC_W-1:0] slot;
        logic [LOC_W-1:0] block;
        logic [LOC_W-1:0] group;
        logic [GEN_W-1:0] gen;
        logic [IDX_W-1:0] idx;
    } t_word;

    typedef struct {
        logic [KIND_W-1:0] kind;
        t_word             w;
    } t_op;

    typedef struct {
        logic [STAT_W-1:0] status;
        t_word             w;
    } t_res;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
        logic [LOC_W-1:0]  grp;
        logic [LOC_W-1:0]  blk;
        logic [LOC_W-1:0]  slt;
        logic              typed;
        logic [STAT_W-1:0] e_status;
        logic [IDX_W-1:0]  e_idx;
        logic [GEN_W-1:0]  e_gen;
        logic [LOC_W-1:0]  e_grp;
        logic [LOC_W-1:0]  e_blk;
        logic [LOC_W-1:0]  e_slt;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    // handle_index, handle_generation, location_group, location_block, location_slot, pad
    logic [DATA_W-1:0] i_s_tdata;
    // kind
    logic [KIND_W-1:0] i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    // out_index, out_generation, out_group, out_block, out_slot, pad
    logic [DATA_W-1:0] o_m_tdata;
    // status
    logic [STAT_W-1:0] o_m_tuser;

    generational_handle_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the table
    t_ght_entry       entry_tbl [GHT_ENTRIES];
    logic [IDX_W-1:0] free_top;
    logic             free_top_ok;
    logic [CNT_W-1:0] fill_count;

    t_res        expected_results [$];
    int unsigned mismatches;
    bit          send_burst;
    t_row        plan [23];

    function automatic logic [LOC_W-1:0] rand16();
        return LOC_W'($urandom_range(0, 65535));
    endfunction

    function automatic t_op make_op(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                    input logic [GEN_W-1:0] gen, input logic [LOC_W-1:0] grp,
                                    input logic [LOC_W-1:0] blk, input logic [LOC_W-1:0] slt);
        t_op op;
        op.kind    = kind;
        op.w       = '0;
        op.w.idx   = idx;
        op.w.gen   = gen;
        op.w.group = grp;
        op.w.block = blk;
        op.w.slot  = slt;
        return op;
    endfunction

    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic bit table_full();
        return !free_top_ok && fill_count == CNT_W'(GHT_ENTRIES);
    endfunction

    function automatic bit pick_live(output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
        idx = '0;
        gen = '0;
        if (fill_count == 0) return 1'b0;
        for (int k = 0; k < 8; k++) begin
            idx = IDX_W'($urandom_range(0, fill_count - 1));
            if (entry_tbl[idx].occupied) begin
                gen = entry_tbl[idx].gen;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic table_apply(input t_op op, output t_res r);
        t_ght_entry       e;
        logic [IDX_W-1:0] at;
        logic [GEN_W-1:0] ng;
        logic             ok;
        r.status = ST_OK;
        r.w      = '0;
        if (op.kind == K_ALLOC) begin
            ok = 1'b1;
            if (free_top_ok) begin
                at          = free_top;
                ng          = entry_tbl[at].gen + 1'b1;
                free_top_ok = entry_tbl[at].link_valid;
                free_top    = entry_tbl[at].link;
            end else if (fill_count < CNT_W'(GHT_ENTRIES)) begin
                at         = fill_count[IDX_W-1:0];
                fill_count = fill_count + 1'b1;
                ng         = GEN_W'(1);
            end else begin
                ok       = 1'b0;
                r.status = ST_FULL;
            end
            if (ok) begin
                e            = '0;
                e.gen        = ng;
                e.group      = op.w.group;
                e.block      = op.w.block;
                e.slot       = op.w.slot;
                e.occupied   = 1'b1;
                entry_tbl[at] = e;
                r.w.idx   = at;
                r.w.gen   = ng;
                r.w.group = op.w.group;
                r.w.block = op.w.block;
                r.w.slot  = op.w.slot;
            end
        end else begin
            at = op.w.idx;
            ok = (CNT_W'(at) < fill_count) && entry_tbl[at].occupied
                 && entry_tbl[at].gen == op.w.gen;
            r.w.idx = at;
            if (!ok) begin
                r.status = ST_STALE;
            end else if (op.kind == K_RECYCLE) begin
                ng = op.w.gen + 1'b1;
                if (ng == '0) ng = GEN_W'(1);
                e            = '0;
                e.gen        = ng;
                e.link_valid = free_top_ok;
                e.link       = free_top;
                entry_tbl[at] = e;
                free_top     = at;
                free_top_ok  = 1'b1;
                r.w.gen      = ng;
            end else begin
                if (op.kind == K_REMAP) begin
                    entry_tbl[at].group = op.w.group;
                    entry_tbl[at].block = op.w.block;
                    entry_tbl[at].slot  = op.w.slot;
                end
                r.w.gen   = entry_tbl[at].gen;
                r.w.group = entry_tbl[at].group;
                r.w.block = entry_tbl[at].block;
                r.w.slot  = entry_tbl[at].slot;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task automatic check_result(input t_word w, input logic [STAT_W-1:0] st);
        t_res e;
        if (expected_results.size() == 0) begin
            flag_mismatch("unexpected word", 32'(st), 32'(0));
        end else begin
            e = expected_results.pop_front();
            if (st !== e.status) flag_mismatch("status", 32'(st), 32'(e.status));
            if (w.idx !== e.w.idx) flag_mismatch("index", 32'(w.idx), 32'(e.w.idx));
            if (w.gen !== e.w.gen) flag_mismatch("generation", 32'(w.gen), 32'(e.w.gen));
            if (w.group !== e.w.group) flag_mismatch("group", 32'(w.group), 32'(e.w.group));
            if (w.block !== e.w.block) flag_mismatch("block", 32'(w.block), 32'(e.w.block));
            if (w.slot !== e.w.slot) flag_mismatch("slot", 32'(w.slot), 32'(e.w.slot));
        end
    endtask

    // offer one word, keep tvalid up when there is no gap
    task automatic put_word(input t_op op, input bit typed, input t_res typed_res,
                            output t_res pred);
        int unsigned gap;
        gap = draw_gap(send_burst);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= op.w;
        i_s_tuser  <= op.kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        table_apply(op, pred);
        if (typed) begin
            expected_results = {expected_results, typed_res};
        end else begin
            expected_results = {expected_results, pred};
        end
    endtask

    task automatic send_op(input t_op op, output t_res pred);
        t_res unused;
        unused.status = ST_OK;
        unused.w      = '0;
        put_word(op, 1'b0, unused, pred);
    endtask

    initial begin : result_side
        int unsigned stall;
        int unsigned taken;
        bit          burst;
        bit          held;
        i_m_tready = 1'b0;
        stall = 0;
        taken = 0;
        burst = 1'b0;
        held  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                check_result(o_m_tdata, o_m_tuser);
                taken++;
                stall = draw_gap(burst);
                // long hold-off so the block backs up and stalls its input
                if (!held && taken == 60) begin
                    held  = 1'b1;
                    stall = 300;
                end
            end
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #36_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_op              op;
        t_res             want;
        t_res             got;
        logic [IDX_W-1:0] hidx;
        logic [GEN_W-1:0] hgen;
        int unsigned      pick;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = K_ALLOC;
        mismatches  = 0;
        send_burst  = 1'b0;
        free_top    = '0;
        free_top_ok = 1'b0;
        fill_count  = '0;
        foreach (entry_tbl[n]) entry_tbl[n] = '0;

        plan = '{
            '{K_LOOKUP, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_RECYCLE, 10'd1023, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_REMAP, 10'd5, 16'h0001, 16'h1111, 16'h2222, 16'h3333,
              1'b1, ST_STALE, 10'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_ALLOC, 10'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b1, ST_OK, 10'd0, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{K_ALLOC, 10'd1023, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_OK, 10'd1, 16'h0001, 16'h0000, 16'h0000, 16'h0000},
            '{K_LOOKUP, 10'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_OK, 10'd0, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{K_LOOKUP, 10'd0, 16'h0002, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_LOOKUP, 10'd2, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_REMAP, 10'd1, 16'h0001, 16'h1234, 16'h5678, 16'h9ABC,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_LOOKUP, 10'd1, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_REMAP, 10'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_RECYCLE, 10'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_OK, 10'd0, 16'h0002, 16'h0000, 16'h0000, 16'h0000},
            // double recycle and a recycle of a free entry with its stored generation
            '{K_RECYCLE, 10'd0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_RECYCLE, 10'd0, 16'h0002, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_LOOKUP, 10'd0, 16'h0002, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_ALLOC, 10'd0, 16'h0000, 16'hAAAA, 16'h5555, 16'h0F0F,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_RECYCLE, 10'd1, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_RECYCLE, 10'd0, 16'h0003, 16'h0000, 16'h0000, 16'h0000,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_ALLOC, 10'd0, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_ALLOC, 10'd0, 16'h0000, 16'h0004, 16'h0005, 16'h0006,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_ALLOC, 10'd0, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_LOOKUP, 10'd1023, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
              1'b1, ST_STALE, 10'd1023, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{K_REMAP, 10'd2, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b0, ST_OK, 10'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            op = make_op(plan[n].kind, plan[n].idx, plan[n].gen,
                         plan[n].grp, plan[n].blk, plan[n].slt);
            want.status  = plan[n].e_status;
            want.w       = '0;
            want.w.idx   = plan[n].e_idx;
            want.w.gen   = plan[n].e_gen;
            want.w.group = plan[n].e_grp;
            want.w.block = plan[n].e_blk;
            want.w.slot  = plan[n].e_slt;
            put_word(op, plan[n].typed, want, got);
        end

        // fill the table, then knock on it while full
        while (!table_full()) begin
            if ($urandom_range(0, 4) == 0 && pick_live(hidx, hgen)) begin
                op = make_op($urandom_range(0, 1) ? K_LOOKUP : K_REMAP, hidx, hgen,
                             rand16(), rand16(), rand16());
            end else begin
                op = make_op(K_ALLOC, IDX_W'($urandom), rand16(), rand16(), rand16(), rand16());
            end
            send_op(op, got);
        end
        repeat (3) send_op(make_op(K_ALLOC, 10'd0, 16'h0000, rand16(), rand16(), rand16()), got);

        for (int n = 0; n < 120; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                op = make_op(K_ALLOC, IDX_W'($urandom), rand16(), rand16(), rand16(), rand16());
            end else if (pick < 85 && pick_live(hidx, hgen)) begin
                if (pick < 55)
                    op = make_op(K_RECYCLE, hidx, hgen, rand16(), rand16(), rand16());
                else if (pick < 70)
                    op = make_op(K_LOOKUP, hidx, hgen, rand16(), rand16(), rand16());
                else
                    op = make_op(K_REMAP, hidx, hgen, rand16(), rand16(), rand16());
            end else if (pick < 92 && pick_live(hidx, hgen)) begin
                // right slot, wrong generation
                op = make_op(KIND_W'($urandom_range(1, 3)), hidx,
                             hgen + GEN_W'($urandom_range(1, 3)),
                             rand16(), rand16(), rand16());
            end else begin
                op = make_op(KIND_W'($urandom), IDX_W'($urandom), rand16(),
                             rand16(), rand16(), rand16());
            end
            send_op(op, got);
        end
        i_s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
